/* sv/sdm_pkg.sv */
// ============================================================================
// sdm_pkg : shared types and constants for the seven-segment display mux
// Request codes, register indexes, segment lookup and inter-module structs.
// ============================================================================
package sdm_pkg;

    // request kinds carried on s_tuser
    typedef enum logic [1:0] {
        REQ_TICK     = 2'd0,
        REQ_LOAD_DEC = 2'd1,
        REQ_LOAD_HEX = 2'd2,
        REQ_UNUSED   = 2'd3
    } req_t;

    // configuration register indexes
    localparam logic [0:0] CFG_RAW_MODE    = 1'b0;
    localparam logic [0:0] CFG_RAW_PATTERN = 1'b1;

    localparam int unsigned BITS_PER_FRAME = 8;
    localparam logic [7:0]  SEL_BIT        = 8'h80;

    // configuration as seen by the datapath
    typedef struct packed {
        logic        raw_mode;
        logic [15:0] raw_pattern;
    } sdm_cfg_t;

    // frame handed from the digit stage to the serialiser
    typedef struct packed {
        logic       valid;
        logic [7:0] pattern;
    } sdm_frame_t;

    // hex digit to segment pattern (gfedcba, active high)
    function automatic logic [7:0] seg_lookup(input logic [3:0] nib);
        logic [7:0] seg;
        case (nib)
            4'h0:    seg = 8'h3f;
            4'h1:    seg = 8'h06;
            4'h2:    seg = 8'h5b;
            4'h3:    seg = 8'h4f;
            4'h4:    seg = 8'h66;
            4'h5:    seg = 8'h6d;
            4'h6:    seg = 8'h7d;
            4'h7:    seg = 8'h07;
            4'h8:    seg = 8'h7f;
            4'h9:    seg = 8'h6f;
            4'ha:    seg = 8'h77;
            4'hb:    seg = 8'h7c;
            4'hc:    seg = 8'h39;
            4'hd:    seg = 8'h5e;
            4'he:    seg = 8'h79;
            4'hf:    seg = 8'h71;
            default: seg = 8'h00;
        endcase
        return seg;
    endfunction

endpackage

/* sv/sdm_digit.sv */
// ============================================================================
// sdm_digit : request register, display state and segment selection
// Holds one request, updates the display byte on loads, builds frames on ticks.
// ============================================================================
module sdm_digit
    import sdm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] in_req,
    input  logic [7:0] in_value,
    input  sdm_cfg_t   cfg,
    output sdm_frame_t frame,
    input  logic       frame_ready
);

    logic       req_valid_reg;
    logic [1:0] req_type_reg;
    logic [7:0] req_value_reg;
    logic [7:0] display_reg;
    logic [7:0] display_next;
    logic       phase_reg;

    logic        is_tick;
    logic        fire;
    logic [15:0] prod;
    logic [4:0]  tens;
    logic [7:0] tens_x10;
    logic [7:0] units;
    logic [7:0] pattern;

    assign is_tick  = (req_t'(req_type_reg) == REQ_TICK);
    assign fire     = req_valid_reg && (!is_tick || frame_ready);
    assign in_ready = !req_valid_reg || fire;

    // v / 10 by reciprocal, exact for 8-bit v
    assign prod     = {8'd0, req_value_reg} * 16'd205;
    assign tens     = prod[15:11];
    assign tens_x10 = {tens, 3'b000} + {2'b00, tens, 1'b0};
    assign units    = req_value_reg - tens_x10;

    always_comb
    begin
        display_next = display_reg;
        case (req_t'(req_type_reg))
            REQ_LOAD_DEC: display_next = {tens[3:0], units[3:0]};
            REQ_LOAD_HEX: display_next = req_value_reg;
            default:      display_next = display_reg;
        endcase
    end

    always_comb
    begin
        if (!phase_reg)
        begin
            pattern = cfg.raw_mode ? cfg.raw_pattern[15:8] : seg_lookup(display_reg[7:4]);
        end
        else
        begin
            pattern = SEL_BIT |
                      (cfg.raw_mode ? cfg.raw_pattern[7:0] : seg_lookup(display_reg[3:0]));
        end
    end

    assign frame.valid   = req_valid_reg && is_tick;
    assign frame.pattern = pattern;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            display_reg   <= 8'h00;
            phase_reg     <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                req_valid_reg <= in_valid;
            end
            if (fire)
            begin
                display_reg <= display_next;
                if (is_tick)
                begin
                    phase_reg <= !phase_reg;
                end
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            req_type_reg  <= in_req;
            req_value_reg <= in_value;
        end
    end

`ifndef ASSERT_OFF
    a_phase_toggle: assert property (@(posedge clk) disable iff (!rst_n)
        fire && is_tick |=> phase_reg != $past(phase_reg))
        else $error("digit phase did not toggle after tick");
    a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(fire && is_tick) |=> $stable(phase_reg))
        else $error("digit phase moved without tick");
    a_display_hold_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        !(fire && !is_tick) |=> $stable(display_reg))
        else $error("display byte changed without load");
`endif

endmodule

/* sv/sdm_serial.sv */
// ============================================================================
// sdm_serial : eight-bit serialiser, MSB first
// Shifts one frame out a bit per transfer and marks the eighth bit.
// ============================================================================
module sdm_serial
    import sdm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  sdm_frame_t frame,
    output logic       frame_ready,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       out_bit,
    output logic       out_last
);

    localparam logic [2:0] LAST_CNT = 3'(BITS_PER_FRAME - 1);

    logic       busy_reg;
    logic [2:0] cnt_reg;
    logic [7:0] shift_reg;
    logic       take;

    assign out_valid   = busy_reg;
    assign out_bit     = shift_reg[7];
    assign out_last    = busy_reg && (cnt_reg == LAST_CNT);
    assign take        = busy_reg && out_ready;
    assign frame_ready = !busy_reg || (out_ready && cnt_reg == LAST_CNT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 3'd0;
        end
        else if (frame.valid && frame_ready)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= 3'd0;
        end
        else if (take)
        begin
            if (cnt_reg == LAST_CNT)
            begin
                busy_reg <= 1'b0;
            end
            cnt_reg <= cnt_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame.valid && frame_ready)
        begin
            shift_reg <= frame.pattern;
        end
        else if (take)
        begin
            shift_reg <= {shift_reg[6:0], 1'b0};
        end
    end

`ifndef ASSERT_OFF
    a_stay_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && cnt_reg != LAST_CNT |=> busy_reg)
        else $error("serialiser dropped a frame early");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        take && cnt_reg != LAST_CNT |=> cnt_reg == $past(cnt_reg) + 3'd1)
        else $error("bit count skipped");
    a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        frame.valid && frame_ready |=> busy_reg && cnt_reg == 3'd0)
        else $error("frame load not started cleanly");
`endif

endmodule

/* sv/two_digit_seven_segment_mux_top.sv */
// ============================================================================
// two_digit_seven_segment_mux_top : two-digit multiplexed display driver
// Stores a display byte and sends one digit's segment frame serially per tick.
// ============================================================================
//
//  channel | signals                              | payload
//  --------+--------------------------------------+------------------------------
//  s_*     | s_tvalid s_tready s_tdata s_tuser    | tdata: load_value[7:0]
//          |                                      | tuser: req_type[1:0]
//  m_*     | m_tvalid m_tready m_tdata m_tlast    | tdata[0]: data_bit, tlast: is_last
//  cfg_*   | cfg_valid cfg_ready cfg_index cfg_data | 0: raw mode, 1: raw pattern
//
// A tick yields eight output transfers, one per bit; the serialiser paces
// the ticks and takes the next frame as the last bit of the current one is
// accepted. Loads are absorbed while a frame is still shifting.
// Reset clears the display byte, the phase (high digit first) and both
// registers. m_tready low holds the current bit; the request register then
// holds one tick and s_tready drops until the serialiser frees.
//
module two_digit_seven_segment_mux_top
    import sdm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] load_value
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    // serial bit stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [0] data_bit, [7:1] zero
    output logic        m_tlast,   // is_last
    // register writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic        raw_mode_reg;
    logic [15:0] raw_pattern_reg;
    sdm_cfg_t    cfg;
    sdm_frame_t  frame;
    logic        frame_ready;
    logic        out_bit;

    // registers are always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_mode_reg    <= 1'b0;
            raw_pattern_reg <= 16'h0000;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_RAW_MODE:    raw_mode_reg    <= cfg_data[0];
                CFG_RAW_PATTERN: raw_pattern_reg <= cfg_data;
                default:         raw_mode_reg    <= raw_mode_reg;
            endcase
        end
    end

    assign cfg.raw_mode    = raw_mode_reg;
    assign cfg.raw_pattern = raw_pattern_reg;

    // request register, display state, segment lookup
    sdm_digit u_digit (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_req      (s_tuser),
        .in_value    (s_tdata),
        .cfg         (cfg),
        .frame       (frame),
        .frame_ready (frame_ready)
    );

    // frame to bit stream
    sdm_serial u_serial (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame       (frame),
        .frame_ready (frame_ready),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_bit     (out_bit),
        .out_last    (m_tlast)
    );

    assign m_tdata = {7'd0, out_bit};

`ifndef ASSERT_OFF
    a_last_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tlast |-> m_tvalid)
        else $error("tlast without tvalid");
    a_no_accept_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready && !frame_ready |=> m_tvalid)
        else $error("output lost while stalled");
    a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tlast && !frame.valid |=> !m_tvalid)
        else $error("bits emitted past end of frame");
`endif

endmodule
